// File: hw/rtl/complementary_attitude_filter_core_assert.svh
// Assertion macros for the complementary attitude filter core.
// Included by the RTL files that carry concurrent checks.
`ifndef COMPLEMENTARY_ATTITUDE_FILTER_CORE_ASSERT_SVH
`define COMPLEMENTARY_ATTITUDE_FILTER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CAF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// antecedent implies consequent in the next cycle
`define CAF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// File: hw/rtl/caf_pkg.sv
// Shared constants and helpers for the complementary attitude filter.
// No dependencies.
`timescale 1ns / 1ps

package caf_pkg;

   localparam int ZFRAC    = 24;
   localparam int PRESCALE = 14;

   localparam logic [1:0] CSR_GYRO_RANGE   = 2'd0;
   localparam logic [1:0] CSR_BLEND_WEIGHT = 2'd1;
   localparam logic [1:0] CSR_STEP_TIME    = 2'd2;

   localparam logic [1:0]  GYRO_RANGE_RST   = 2'd0;
   localparam logic [16:0] BLEND_WEIGHT_RST = 17'd64225;
   localparam logic [19:0] STEP_TIME_RST    = 20'd10486;
   localparam logic [16:0] ALPHA_ONE        = 17'd65536;

   // atan(2^-i) in Q.24 degrees; small-angle tail is deg/rad scaled down
   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'd754974720;
         5'd1:  r = 32'd445687602;
         5'd2:  r = 32'd235489088;
         5'd3:  r = 32'd119537938;
         5'd4:  r = 32'd60000934;
         5'd5:  r = 32'd30029717;
         5'd6:  r = 32'd15018523;
         5'd7:  r = 32'd7509720;
         5'd8:  r = 32'd3754917;
         5'd9:  r = 32'd1877466;
         5'd10: r = 32'd938734;
         5'd11: r = 32'd469367;
         default: r = 32'd961263669 >> i;
      endcase
      return r;
   endfunction

   // gyro sensitivity, tenths of an LSB per deg/s
   function automatic logic [10:0] sens10(input logic [1:0] rng);
      logic [10:0] r;
      case (rng)
         2'd0: r = 11'd1310;
         2'd1: r = 11'd655;
         2'd2: r = 11'd328;
         default: r = 11'd164;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// File: hw/rtl/complementary_attitude_filter_core.sv
// Complementary attitude filter: roll, pitch and yaw from raw six-axis samples.
// Depends on caf_pkg and complementary_attitude_filter_core_assert.svh.
`timescale 1ns / 1ps
`include "complementary_attitude_filter_core_assert.svh"

// One request in, one roll/pitch/yaw response out. A single sequencer drives
// a shared shift-add datapath: a CORDIC pass for roll, a bit-serial square
// root, a CORDIC pass for pitch, then for each gyro axis a multiply and a
// restoring divide, then blending of roll and pitch and integration of yaw.
// The first request after reset skips the gyro work and the blending.
// req_stall is high for the whole computation. A finished response sits in
// the output register, so the next request is taken while it waits.
module complementary_attitude_filter_core
   import caf_pkg::*;
#(
   parameter int CORDIC_STEPS    = 20,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_rate_x,
   input  logic signed [15:0] req_rate_y,
   input  logic signed [15:0] req_rate_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_roll_angle,
   output logic signed [31:0] rsp_pitch_angle,
   output logic signed [31:0] rsp_yaw_angle,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [19:0]        csr_data
);

   localparam int QW    = ANGLE_FRAC_BITS + 14;
   localparam int IW    = QW + 1;
   localparam int NW    = ANGLE_FRAC_BITS + 46;
   localparam int ZSH   = ZFRAC - ANGLE_FRAC_BITS;
   localparam int MAXC  = (QW > 31) ? QW : 31;
   localparam int CNT_W = $clog2(MAXC + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CINIT  = 4'd1;
   localparam logic [3:0] S_CITER  = 4'd2;
   localparam logic [3:0] S_CFIN   = 4'd3;
   localparam logic [3:0] S_SQINIT = 4'd4;
   localparam logic [3:0] S_SQ     = 4'd5;
   localparam logic [3:0] S_GMUL   = 4'd6;
   localparam logic [3:0] S_GLOAD  = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;
   localparam logic [3:0] S_BLA    = 4'd9;
   localparam logic [3:0] S_BLB    = 4'd10;
   localparam logic [3:0] S_YAW    = 4'd11;
   localparam logic [3:0] S_INIT   = 4'd12;
   localparam logic [3:0] S_OUT    = 4'd13;

   logic [3:0]         state_ff;
   logic [1:0]         gyro_range_ff;
   logic [16:0]        blend_weight_ff;
   logic [19:0]        step_time_ff;
   logic               primed_ff;
   logic signed [31:0] prev_ff [3];
   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic signed [15:0] g_ff [3];
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic               pass_ff;
   logic [1:0]         axis_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [61:0]        sqn_ff, sqres_ff;
   logic signed [31:0] acc_ff [2];
   logic [35:0]        m_ff;
   logic [NW-1:0]      rem_ff;
   logic [QW-1:0]      q_ff;
   logic signed [IW-1:0] inc_ff [3];
   logic signed [55:0] prod_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] roll_ff, pitch_ff, yaw_ff;

   // CORDIC operand selection and pre-rotation
   logic signed [33:0] xi, yi, xr, yr, zr0;
   always_comb begin
      if (!pass_ff) begin
         xi = {{4{az_ff[15]}}, az_ff, 14'b0};
         yi = {{4{ay_ff[15]}}, ay_ff, 14'b0};
      end else begin
         xi = {4'b0, sqres_ff[29:0]};
         yi = -{{4{ax_ff[15]}}, ax_ff, 14'b0};
      end
      xr  = xi;
      yr  = yi;
      zr0 = '0;
      if (xi < 0) begin
         if (yi >= 0) begin
            xr  = yi;
            yr  = -xi;
            zr0 = 34'sd1509949440;
         end else begin
            xr  = -yi;
            yr  = xi;
            zr0 = -34'sd1509949440;
         end
      end
   end

   // shared shift-add step
   logic signed [33:0] xs, ys, ang, zrnd;
   assign xs   = x_ff >>> cnt_ff;
   assign ys   = y_ff >>> cnt_ff;
   assign ang  = $signed({2'b0, atan_entry(cnt_ff[4:0])});
   assign zrnd = (z_ff + (34'sd1 <<< (ZSH - 1))) >>> ZSH;

   // square root trial
   logic [61:0] sq_bit, sq_trial;
   logic signed [31:0] sq_y, sq_z;
   assign sq_bit   = 62'd1 << {cnt_ff, 1'b0};
   assign sq_trial = sqres_ff + sq_bit;
   assign sq_y     = ay_ff * ay_ff;
   assign sq_z     = az_ff * az_ff;

   // gyro scaling and divide
   logic signed [15:0] raw_sel;
   logic [15:0]        raw_abs;
   logic [10:0]        sens;
   logic [39:0]        m10;
   logic [NW-1:0]      dsh;
   logic               ge;
   logic [QW-1:0]      qn;
   assign raw_sel = g_ff[axis_ff];
   assign raw_abs = raw_sel[15] ? 16'(-raw_sel) : 16'(raw_sel);
   assign sens    = sens10(gyro_range_ff);
   assign m10     = (40'(m_ff) << 3) + (40'(m_ff) << 1);
   assign dsh     = NW'(sens) << (20 + int'(cnt_ff));
   assign ge      = rem_ff >= dsh;
   assign qn      = {q_ff[QW-2:0], ge};

   // blend
   logic [16:0]        alpha, alpha_n;
   logic signed [35:0] pred;
   logic signed [55:0] bsum;
   assign alpha   = (blend_weight_ff > ALPHA_ONE) ? ALPHA_ONE : blend_weight_ff;
   assign alpha_n = ALPHA_ONE - alpha;
   assign pred    = 36'(prev_ff[axis_ff]) + 36'(inc_ff[axis_ff]);
   assign bsum    = prod_ff + 56'($signed({1'b0, alpha_n})) * 56'(acc_ff[axis_ff[0]])
                    + 56'sd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         primed_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         gyro_range_ff   <= GYRO_RANGE_RST;
         blend_weight_ff <= BLEND_WEIGHT_RST;
         step_time_ff    <= STEP_TIME_RST;
         prev_ff[0]      <= '0;
         prev_ff[1]      <= '0;
         prev_ff[2]      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GYRO_RANGE:   gyro_range_ff   <= csr_data[1:0];
               CSR_BLEND_WEIGHT: blend_weight_ff <= csr_data[16:0];
               CSR_STEP_TIME:    step_time_ff    <= csr_data;
               default: ;
            endcase
         end
         // S_OUT handles the valid flag itself when it hands over
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ax_ff    <= req_accel_x;
                  ay_ff    <= req_accel_y;
                  az_ff    <= req_accel_z;
                  g_ff[0]  <= req_rate_x;
                  g_ff[1]  <= req_rate_y;
                  g_ff[2]  <= req_rate_z;
                  pass_ff  <= 1'b0;
                  state_ff <= S_CINIT;
               end
            end
            S_CINIT: begin
               x_ff   <= xr;
               y_ff   <= yr;
               z_ff   <= zr0;
               cnt_ff <= '0;
               if (xi == 0 && yi == 0) begin
                  acc_ff[pass_ff] <= '0;
                  if (!pass_ff) state_ff <= S_SQINIT;
                  else begin
                     axis_ff  <= 2'd0;
                     state_ff <= primed_ff ? S_GMUL : S_INIT;
                  end
               end else begin
                  state_ff <= S_CITER;
               end
            end
            S_CITER: begin
               if (y_ff > 0) begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  z_ff <= z_ff + ang;
               end else begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  z_ff <= z_ff - ang;
               end
               if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) state_ff <= S_CFIN;
               else cnt_ff <= cnt_ff + 1'b1;
            end
            S_CFIN: begin
               acc_ff[pass_ff] <= zrnd[31:0];
               if (!pass_ff) state_ff <= S_SQINIT;
               else begin
                  axis_ff  <= 2'd0;
                  state_ff <= primed_ff ? S_GMUL : S_INIT;
               end
            end
            S_SQINIT: begin
               sqn_ff   <= (62'(sq_y[31:0]) + 62'(sq_z[31:0])) << (2 * PRESCALE);
               sqres_ff <= '0;
               cnt_ff   <= CNT_W'(30);
               state_ff <= S_SQ;
            end
            S_SQ: begin
               if (sqn_ff >= sq_trial) begin
                  sqn_ff   <= sqn_ff - sq_trial;
                  sqres_ff <= (sqres_ff >> 1) + sq_bit;
               end else begin
                  sqres_ff <= sqres_ff >> 1;
               end
               if (cnt_ff == '0) begin
                  pass_ff  <= 1'b1;
                  state_ff <= S_CINIT;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            S_GMUL: begin
               m_ff     <= raw_abs * step_time_ff;
               state_ff <= S_GLOAD;
            end
            S_GLOAD: begin
               rem_ff   <= (NW'(m10) << ANGLE_FRAC_BITS) + (NW'(sens) << 19);
               q_ff     <= '0;
               cnt_ff   <= CNT_W'(QW - 1);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (ge) rem_ff <= rem_ff - dsh;
               q_ff <= qn;
               if (cnt_ff == '0) begin
                  inc_ff[axis_ff] <= raw_sel[15] ? -$signed({1'b0, qn})
                                                 : $signed({1'b0, qn});
                  if (axis_ff == 2'd2) begin
                     axis_ff  <= 2'd0;
                     state_ff <= S_BLA;
                  end else begin
                     axis_ff  <= axis_ff + 1'b1;
                     state_ff <= S_GMUL;
                  end
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            S_BLA: begin
               prod_ff  <= 56'($signed({1'b0, alpha})) * 56'(pred);
               state_ff <= S_BLB;
            end
            S_BLB: begin
               prev_ff[axis_ff] <= sat32(64'(bsum >>> 16));
               if (axis_ff == 2'd0) begin
                  axis_ff  <= 2'd1;
                  state_ff <= S_BLA;
               end else begin
                  state_ff <= S_YAW;
               end
            end
            S_YAW: begin
               prev_ff[2] <= sat32(64'(prev_ff[2]) + 64'(inc_ff[2]));
               state_ff   <= S_OUT;
            end
            S_INIT: begin
               prev_ff[0] <= acc_ff[0];
               prev_ff[1] <= acc_ff[1];
               prev_ff[2] <= '0;
               primed_ff  <= 1'b1;
               state_ff   <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  roll_ff      <= prev_ff[0];
                  pitch_ff     <= prev_ff[1];
                  yaw_ff       <= prev_ff[2];
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign csr_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;

   `CAF_ASSERT_NEXT(a_req_starts, clock, reset, req_valid && !req_stall, state_ff == S_CINIT)
   `CAF_ASSERT_SAME(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_OUT)
   `CAF_ASSERT_SAME(a_cordic_bound, clock, reset, state_ff == S_CITER, cnt_ff < CORDIC_STEPS)

endmodule
